// ===== rtl/mba_pkg.sv =====
// Shared types, codes and helpers of the minute bar aggregator.
`default_nettype none
package mba_pkg;
    localparam int SYM_W = 5;
    localparam int MIN_W = 32;
    localparam int PRC_W = 32;
    localparam int QTY_W = 32;
    localparam int SUM_W = 48;
    localparam int SYM_LIMIT = 32;

    // Action codes of an input word
    typedef enum logic [1:0] {
        OP_TRADE = 2'd0,
        OP_QUOTE = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Record kind codes
    localparam logic KIND_TRADE = 1'b0;
    localparam logic KIND_QUOTE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN_T,
        ST_SCAN_Q,
        ST_APPLY
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [SYM_W-1:0] symbol;
        logic [MIN_W-1:0] minute;
        logic [PRC_W-1:0] price;
        logic [QTY_W-1:0] volume;
        logic [QTY_W-1:0] bid_size;
        logic [QTY_W-1:0] ask_size;
    } t_cmd;

    typedef struct packed {
        logic             kind;
        logic [SYM_W-1:0] bar_symbol;
        logic [MIN_W-1:0] bar_minute;
        logic [PRC_W-1:0] open_price;
        logic [PRC_W-1:0] high_price;
        logic [PRC_W-1:0] low_price;
        logic [PRC_W-1:0] close_price;
        logic [SUM_W-1:0] total_volume;
        logic [SUM_W-1:0] bid_total;
        logic [SUM_W-1:0] ask_total;
        logic             last;
    } t_rec;

    // Add a size to a sum and stop at all ones
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [QTY_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W-QTY_W+1){1'b0}}, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/mba_if.sv =====
// Channel interfaces of the minute bar aggregator.
`default_nettype none
interface mba_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic [mba_pkg::SYM_W-1:0] symbol;
    logic [mba_pkg::MIN_W-1:0] minute;
    logic [mba_pkg::PRC_W-1:0] price;
    logic [mba_pkg::QTY_W-1:0] volume;
    logic [mba_pkg::QTY_W-1:0] bid_size;
    logic [mba_pkg::QTY_W-1:0] ask_size;
    modport source (output valid, action, symbol, minute, price, volume, bid_size,
                     ask_size, input ready);
    modport sink (input valid, action, symbol, minute, price, volume, bid_size,
                  ask_size, output ready);
endinterface

interface mba_out_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [mba_pkg::SYM_W-1:0] bar_symbol;
    logic [mba_pkg::MIN_W-1:0] bar_minute;
    logic [mba_pkg::PRC_W-1:0] open_price;
    logic [mba_pkg::PRC_W-1:0] high_price;
    logic [mba_pkg::PRC_W-1:0] low_price;
    logic [mba_pkg::PRC_W-1:0] close_price;
    logic [mba_pkg::SUM_W-1:0] total_volume;
    logic [mba_pkg::SUM_W-1:0] bid_total;
    logic [mba_pkg::SUM_W-1:0] ask_total;
    logic                       last;
    modport source (output valid, kind, bar_symbol, bar_minute, open_price, high_price,
                     low_price, close_price, total_volume, bid_total, ask_total, last,
                     input ready);
    modport sink (input valid, kind, bar_symbol, bar_minute, open_price, high_price,
                  low_price, close_price, total_volume, bid_total, ask_total, last,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/mba_front.sv =====
// Front end: accept input words, decode the action and queue them.
`default_nettype none
module mba_front import mba_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mba_in_if.sink    i_in,
    output t_cmd      o_cmd,
    output logic      o_cmd_valid,
    input  wire logic i_pop
);
    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push;
    t_cmd       cmd_in;

    assign i_in.ready  = (r_cnt != 2'd2);
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd       = r_mem[r_rd];
    assign o_cmd_valid = (r_cnt != 2'd0);

    // Decode the word into a command
    always_comb begin
        cmd_in.op       = t_op'(i_in.action);
        cmd_in.symbol   = i_in.symbol;
        cmd_in.minute   = i_in.minute;
        cmd_in.price    = i_in.price;
        cmd_in.volume   = i_in.volume;
        cmd_in.bid_size = i_in.bid_size;
        cmd_in.ask_size = i_in.ask_size;
    end

    // Advance queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (i_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end

    // Hold queued words
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= cmd_in;
    end
endmodule
`default_nettype wire

// ===== rtl/mba_back.sv =====
// Back end: bar tables, rollover scans and the output register.
`default_nettype none
module mba_back import mba_pkg::*; #(
    parameter int ENTRIES = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire logic i_cmd_valid,
    output logic      o_pop,
    mba_out_if.source o_out
);
    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    t_state             r_state, n_state;
    t_cmd               r_cmd;
    logic               r_roll;
    logic [IDX_W-1:0]   r_idx;
    logic [MIN_W-1:0]   r_cur_t, r_cur_q;
    logic [ENTRIES-1:0] r_vt, r_vq;
    logic [MIN_W-1:0]   r_tmin [ENTRIES];
    logic [MIN_W-1:0]   r_qmin [ENTRIES];
    logic [PRC_W-1:0]   r_open [ENTRIES];
    logic [PRC_W-1:0]   r_high [ENTRIES];
    logic [PRC_W-1:0]   r_low  [ENTRIES];
    logic [PRC_W-1:0]   r_close[ENTRIES];
    logic [SUM_W-1:0]   r_vol  [ENTRIES];
    logic [SUM_W-1:0]   r_bid  [ENTRIES];
    logic [SUM_W-1:0]   r_ask  [ENTRIES];
    logic               r_ovalid;
    t_rec               r_orec;

    logic               out_free, scanning, cur_valid, step, emit, scan_end;
    logic [ENTRIES-1:0] hi_mask;
    logic               last_rec, roll_now, hit;
    logic [IDX_W-1:0]   a_idx;
    t_rec               rec;

    // Scan control
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) hi_mask[i] = (i > int'(r_idx));
        out_free  = !r_ovalid || o_out.ready;
        scanning  = (r_state == ST_SCAN_T) || (r_state == ST_SCAN_Q);
        cur_valid = (r_state == ST_SCAN_T) ? r_vt[r_idx] : r_vq[r_idx];
        step      = scanning && (!cur_valid || out_free);
        emit      = scanning && cur_valid && out_free;
        scan_end  = step && (r_idx == IDX_LAST);
        if (r_state == ST_SCAN_T)
            last_rec = !(|(r_vt & hi_mask)) && !((r_cmd.op == OP_FLUSH) && (|r_vq));
        else
            last_rec = !(|(r_vq & hi_mask));
        hit   = ({{(32-SYM_W){1'b0}}, r_cmd.symbol} < 32'(ENTRIES));
        a_idx = IDX_W'(r_cmd.symbol);
        case (i_cmd.op)
            OP_TRADE: roll_now = (r_cur_t < i_cmd.minute);
            OP_QUOTE: roll_now = (r_cur_q < i_cmd.minute);
            default:  roll_now = 1'b0;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_TRADE: n_state = roll_now ? ST_SCAN_T : ST_APPLY;
                        OP_QUOTE: n_state = roll_now ? ST_SCAN_Q : ST_APPLY;
                        OP_FLUSH: n_state = ST_SCAN_T;
                        default:  n_state = ST_APPLY;
                    endcase
                end
            end
            ST_SCAN_T: begin
                if (scan_end) n_state = (r_cmd.op == OP_FLUSH) ? ST_SCAN_Q : ST_APPLY;
            end
            ST_SCAN_Q: begin
                if (scan_end) n_state = ST_APPLY;
            end
            ST_APPLY: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs: pop strobe and the record being emitted
    always_comb begin
        o_pop = (r_state == ST_IDLE) && i_cmd_valid;
        rec   = '0;
        rec.bar_symbol = SYM_W'(r_idx);
        rec.last       = last_rec;
        if (r_state == ST_SCAN_T) begin
            rec.kind         = KIND_TRADE;
            rec.bar_minute   = r_tmin[r_idx];
            rec.open_price   = r_open[r_idx];
            rec.high_price   = r_high[r_idx];
            rec.low_price    = r_low[r_idx];
            rec.close_price  = r_close[r_idx];
            rec.total_volume = r_vol[r_idx];
        end else begin
            rec.kind       = KIND_QUOTE;
            rec.bar_minute = r_qmin[r_idx];
            rec.bid_total  = r_bid[r_idx];
            rec.ask_total  = r_ask[r_idx];
        end
    end

    // Control state, valid bits and current minutes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_vt     <= '0;
            r_vq     <= '0;
            r_cur_t  <= '0;
            r_cur_q  <= '0;
        end else begin
            r_state <= n_state;
            if (emit) r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
            if (emit && r_state == ST_SCAN_T) r_vt[r_idx] <= 1'b0;
            if (emit && r_state == ST_SCAN_Q) r_vq[r_idx] <= 1'b0;
            if (r_state == ST_APPLY) begin
                case (r_cmd.op)
                    OP_TRADE: begin
                        if (r_roll) r_cur_t <= r_cmd.minute;
                        if (hit) r_vt[a_idx] <= 1'b1;
                    end
                    OP_QUOTE: begin
                        if (r_roll) r_cur_q <= r_cmd.minute;
                        if (hit) r_vq[a_idx] <= 1'b1;
                    end
                    OP_FLUSH: begin
                        if (r_cur_t != {MIN_W{1'b1}}) r_cur_t <= r_cur_t + MIN_W'(1);
                        if (r_cur_q != {MIN_W{1'b1}}) r_cur_q <= r_cur_q + MIN_W'(1);
                    end
                    default: ;
                endcase
            end
        end
    end

    // Command, scan index, output record and table contents
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd  <= i_cmd;
            r_roll <= roll_now;
            r_idx  <= '0;
        end else if (step) begin
            r_idx <= (r_idx == IDX_LAST) ? '0 : r_idx + IDX_W'(1);
        end
        if (emit) r_orec <= rec;
        if (r_state == ST_APPLY && hit) begin
            if (r_cmd.op == OP_TRADE) begin
                if (!r_vt[a_idx]) begin
                    r_tmin[a_idx]  <= r_cmd.minute;
                    r_open[a_idx]  <= r_cmd.price;
                    r_high[a_idx]  <= r_cmd.price;
                    r_low[a_idx]   <= r_cmd.price;
                    r_close[a_idx] <= r_cmd.price;
                    r_vol[a_idx]   <= {{(SUM_W-QTY_W){1'b0}}, r_cmd.volume};
                end else begin
                    if (r_high[a_idx] < r_cmd.price) r_high[a_idx] <= r_cmd.price;
                    if (r_low[a_idx] > r_cmd.price) r_low[a_idx] <= r_cmd.price;
                    r_close[a_idx] <= r_cmd.price;
                    r_vol[a_idx]   <= sat_add(r_vol[a_idx], r_cmd.volume);
                end
            end
            if (r_cmd.op == OP_QUOTE) begin
                if (!r_vq[a_idx]) begin
                    r_qmin[a_idx] <= r_cmd.minute;
                    r_bid[a_idx]  <= sat_add('0, r_cmd.bid_size);
                    r_ask[a_idx]  <= sat_add('0, r_cmd.ask_size);
                end else begin
                    r_bid[a_idx] <= sat_add(r_bid[a_idx], r_cmd.bid_size);
                    r_ask[a_idx] <= sat_add(r_ask[a_idx], r_cmd.ask_size);
                end
            end
        end
    end

    // Drive the output channel from the register
    assign o_out.valid        = r_ovalid;
    assign o_out.kind         = r_orec.kind;
    assign o_out.bar_symbol   = r_orec.bar_symbol;
    assign o_out.bar_minute   = r_orec.bar_minute;
    assign o_out.open_price   = r_orec.open_price;
    assign o_out.high_price   = r_orec.high_price;
    assign o_out.low_price    = r_orec.low_price;
    assign o_out.close_price  = r_orec.close_price;
    assign o_out.total_volume = r_orec.total_volume;
    assign o_out.bid_total    = r_orec.bid_total;
    assign o_out.ask_total    = r_orec.ask_total;
    assign o_out.last         = r_orec.last;
endmodule
`default_nettype wire

// ===== rtl/minute_bar_aggregator.sv =====
// Top level of the per-symbol one-minute bar engine.
//  channel | dir | word
//  i_in    | in  | action, symbol, minute, price, volume, bid_size, ask_size
//  o_out   | out | one trade or quote bar record, last marks the end of an input
// A trade or quote without rollover goes through the table engine as a pop, then an update.
// A rollover adds a scan over every table entry (min(SYMBOLS,32)); a flush adds two such scans.
// A two-word queue decouples input from the engine; the output register lets the
// scan stall only on a valid entry while o_out is not ready.
// Reset is synchronous and clears valid bits and current minutes.
`default_nettype none
module minute_bar_aggregator import mba_pkg::*; #(
    parameter int SYMBOLS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mba_in_if.sink    i_in,
    mba_out_if.source o_out
);
    localparam int ENTRIES = (SYMBOLS < SYM_LIMIT) ? SYMBOLS : SYM_LIMIT;

    t_cmd cmd;
    logic cmd_valid;
    logic pop;

    mba_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_pop       (pop)
    );

    mba_back #(.ENTRIES(ENTRIES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_pop       (pop),
        .o_out       (o_out)
    );
endmodule
`default_nettype wire
